// File: rtl/assert_macros.svh
// shared assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define PBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
  `PBA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/pba_pkg.sv
`default_nettype none

package pba_pkg;

  // fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PADDR_W    = 28;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned MEMMB_W    = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  // width of the shared compare path, covers any page index or count
  localparam int unsigned CMP_W      = 32;
  // log2 of one megabyte
  localparam int unsigned MB_SHIFT   = 20;

  localparam logic [MEMMB_W-1:0] MEM_MB_RST = 9'd256;
  localparam logic [CNT_W-1:0]   RSV_RST    = 17'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_SIZE       = 1'b0,
    CFG_RESERVED_PAGES = 1'b1
  } cfg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SETUP = 8'b0000_0010,
    ST_CLEAR = 8'b0000_0100,
    ST_ARD   = 8'b0000_1000,
    ST_ACHK  = 8'b0001_0000,
    ST_FRD   = 8'b0010_0000,
    ST_FCHK  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

// File: rtl/pba_if.sv
`default_nettype none

// command channel
interface pba_req_if;
  logic                         valid;
  logic                         ready;
  logic [pba_pkg::CMD_W-1:0]    command;
  logic [pba_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

// result channel
interface pba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pba_pkg::STATUS_W-1:0] status;
  logic [pba_pkg::PADDR_W-1:0]  page_address;
  logic [pba_pkg::CNT_W-1:0]    used_count;
  logic [pba_pkg::CNT_W-1:0]    free_count;
  logic [pba_pkg::CNT_W-1:0]    page_total;

  modport source (output valid, output status, output page_address, output used_count,
                  output free_count, output page_total, input ready);
  modport sink   (input valid, input status, input page_address, input used_count,
                  input free_count, input page_total, output ready);
endinterface

`default_nettype wire

// File: rtl/pba_ram.sv
`default_nettype none

module pba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/page_bitmap_allocator_unit.sv
// steps: alloc reads and checks the hint word, again per full word skipped; free reads
//   and checks one word; init sweeps ceil(page_total / MAP_WORD_BITS) words; undefined
//   commands just finish; throughput: one item at a time, the next taken in idle after
//   its result is loaded; a result still waiting in the output register holds it
// reset: counts and page total clear, registers take their defaults; the map ram is
//   not cleared, nothing reads it before an init because the page total is zero
`default_nettype none
`include "assert_macros.svh"

module page_bitmap_allocator_unit #(
  parameter int unsigned PAGES         = 65536,
  parameter int unsigned PAGE_BYTES    = 4096,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pba_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pba_req_if.sink                          req_i,
  pba_rsp_if.source                        rsp_o
);

  // map geometry
  localparam int unsigned Words = PAGES / MAP_WORD_BITS;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned WCntW = $clog2(Words + 1);
  localparam int unsigned BitW  = $clog2(MAP_WORD_BITS);
  localparam int unsigned CntW  = $clog2(PAGES + 1);
  localparam int unsigned PgSh  = $clog2(PAGE_BYTES);
  // pages per megabyte, as a shift
  localparam int unsigned MbSh  = pba_pkg::MB_SHIFT - PgSh;
  localparam int unsigned CW    = pba_pkg::CMP_W;
  localparam logic [MAP_WORD_BITS-1:0] OneBit = MAP_WORD_BITS'(1);

  // control state
  pba_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  limit_q, limit_d;   // page total latched at init
  logic [CntW-1:0]  used_q, used_d;     // pages in use
  // first map word that may hold a clear bit; every word below it is full
  logic [WCntW-1:0] hint_q, hint_d;
  logic [WCntW-1:0] widx_q, widx_d;     // word counter of the init sweep
  logic             ov_q;

  // configuration registers
  logic [pba_pkg::MEMMB_W-1:0] mem_mb_q;
  logic [pba_pkg::CNT_W-1:0]   rsv_q;

  // item payload and working result
  logic [pba_pkg::ADDR_W-1:0]  addr_q;
  pba_pkg::status_e            status_q, status_d;
  logic [pba_pkg::PADDR_W-1:0] paddr_q, paddr_d;

  // output register
  logic [pba_pkg::STATUS_W-1:0] o_status_q;
  logic [pba_pkg::PADDR_W-1:0]  o_paddr_q;
  logic [pba_pkg::CNT_W-1:0]    o_used_q, o_free_q, o_total_q;
  logic                         load_out;

  // map ram port
  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr, ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;

  // shared datapath
  logic [CW-1:0]            hint_base, widx_base, limit_w, used_w;
  logic [CW-1:0]            fidx, mem_total, aidx;
  logic [AddrW-1:0]         fword;
  logic [BitW-1:0]          fbit, fz_bit, clr_n;
  logic [CntW-1:0]          res;
  logic [MAP_WORD_BITS-1:0] clr_word;
  logic                     accept;

  assign accept    = req_i.valid && (state_q == pba_pkg::ST_IDLE);
  assign hint_base = CW'(hint_q) << BitW;
  assign widx_base = CW'(widx_q) << BitW;
  assign limit_w   = CW'(limit_q);
  assign used_w    = CW'(used_q);
  // page index of a free is the address divided by the page size
  assign fidx      = CW'(addr_q >> PgSh);
  assign fword     = fidx[BitW +: AddrW];
  assign fbit      = fidx[BitW-1:0];
  assign mem_total = CW'(mem_mb_q) << MbSh;
  // reserved count clamped to the page total
  assign res       = (CW'(rsv_q) > limit_w) ? limit_q : CntW'(rsv_q);
  assign aidx      = hint_base + CW'(fz_bit);
  assign clr_n     = BitW'(used_w - widx_base);

  // lowest clear bit of the word just read
  always_comb begin
    fz_bit = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        fz_bit = BitW'(i);
      end
    end
  end

  // init pattern: words below the reserved count full, the boundary word partial
  always_comb begin
    if (widx_base + CW'(MAP_WORD_BITS) <= used_w) begin
      clr_word = '1;
    end else if (widx_base >= used_w) begin
      clr_word = '0;
    end else begin
      clr_word = ~({MAP_WORD_BITS{1'b1}} << clr_n);
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    limit_d   = limit_q;
    used_d    = used_q;
    hint_d    = hint_q;
    widx_d    = widx_q;
    status_d  = status_q;
    paddr_d   = paddr_q;
    ram_we    = 1'b0;
    ram_waddr = widx_q[AddrW-1:0];
    ram_wdata = clr_word;
    ram_raddr = hint_q[AddrW-1:0];
    load_out  = 1'b0;
    unique case (state_q)
      pba_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          status_d = pba_pkg::STAT_OK;
          paddr_d  = '0;
          unique case (pba_pkg::cmd_e'(req_i.command))
            pba_pkg::CMD_INIT: begin
              // page count saturates at the map size
              limit_d = (mem_total > CW'(PAGES)) ? CntW'(PAGES) : CntW'(mem_total);
              state_d = pba_pkg::ST_SETUP;
            end
            pba_pkg::CMD_ALLOC: state_d = pba_pkg::ST_ARD;
            pba_pkg::CMD_FREE:  state_d = pba_pkg::ST_FRD;
            default:            state_d = pba_pkg::ST_FIN;
          endcase
        end
      end
      pba_pkg::ST_SETUP: begin
        used_d  = res;
        hint_d  = WCntW'(res >> BitW);
        widx_d  = '0;
        state_d = pba_pkg::ST_CLEAR;
      end
      pba_pkg::ST_CLEAR: begin
        // only words below the page total are ever read, the sweep stops there
        if (widx_base >= limit_w) begin
          state_d = pba_pkg::ST_FIN;
        end else begin
          ram_we = 1'b1;
          widx_d = widx_q + 1'b1;
        end
      end
      pba_pkg::ST_ARD: begin
        if (hint_base >= limit_w) begin
          status_d = pba_pkg::STAT_NOFREE;
          state_d  = pba_pkg::ST_FIN;
        end else begin
          state_d = pba_pkg::ST_ACHK;
        end
      end
      pba_pkg::ST_ACHK: begin
        ram_waddr = hint_q[AddrW-1:0];
        ram_wdata = ram_rdata | (OneBit << fz_bit);
        if (&ram_rdata) begin
          hint_d  = hint_q + 1'b1;
          state_d = pba_pkg::ST_ARD;
        end else if (aidx >= limit_w) begin
          status_d = pba_pkg::STAT_NOFREE;
          state_d  = pba_pkg::ST_FIN;
        end else begin
          ram_we  = 1'b1;
          used_d  = used_q + 1'b1;
          paddr_d = pba_pkg::PADDR_W'(aidx << PgSh);
          state_d = pba_pkg::ST_FIN;
        end
      end
      pba_pkg::ST_FRD: begin
        ram_raddr = fword;
        if (fidx >= limit_w) begin
          status_d = pba_pkg::STAT_RANGE;
          state_d  = pba_pkg::ST_FIN;
        end else begin
          state_d = pba_pkg::ST_FCHK;
        end
      end
      pba_pkg::ST_FCHK: begin
        ram_raddr = fword;
        ram_waddr = fword;
        ram_wdata = ram_rdata & ~(OneBit << fbit);
        // a page already clear leaves everything unchanged
        if (ram_rdata[fbit]) begin
          ram_we = 1'b1;
          used_d = used_q - 1'b1;
          if (CW'(fword) < CW'(hint_q)) begin
            hint_d = WCntW'(fword);
          end
        end
        state_d = pba_pkg::ST_FIN;
      end
      pba_pkg::ST_FIN: begin
        if (!ov_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = pba_pkg::ST_IDLE;
        end
      end
      default: state_d = pba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pba_pkg::ST_IDLE;
      limit_q  <= '0;
      used_q   <= '0;
      hint_q   <= '0;
      widx_q   <= '0;
      ov_q     <= 1'b0;
      mem_mb_q <= pba_pkg::MEM_MB_RST;
      rsv_q    <= pba_pkg::RSV_RST;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      used_q  <= used_d;
      hint_q  <= hint_d;
      widx_q  <= widx_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (pba_pkg::cfg_idx_e'(cfg_idx_i))
          pba_pkg::CFG_MEM_SIZE:       mem_mb_q <= cfg_data_i[pba_pkg::MEMMB_W-1:0];
          pba_pkg::CFG_RESERVED_PAGES: rsv_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_i.address;
    end
    status_q <= status_d;
    paddr_q  <= paddr_d;
    if (load_out) begin
      o_status_q <= status_q;
      o_paddr_q  <= paddr_q;
      o_used_q   <= pba_pkg::CNT_W'(used_q);
      o_free_q   <= pba_pkg::CNT_W'(limit_q - used_q);
      o_total_q  <= pba_pkg::CNT_W'(limit_q);
    end
  end

  pba_ram #(
    .Width (MAP_WORD_BITS),
    .Depth (Words)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready        = (state_q == pba_pkg::ST_IDLE);
  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = o_status_q;
  assign rsp_o.page_address = o_paddr_q;
  assign rsp_o.used_count   = o_used_q;
  assign rsp_o.free_count   = o_free_q;
  assign rsp_o.page_total   = o_total_q;

  // the new page total of an init is latched on entry to setup, the counts on leaving it
  `PBA_ASSERT_IMP(a_used_within_total, state_q != pba_pkg::ST_SETUP, used_q <= limit_q,
                  "used pages exceed page total")
  `PBA_ASSERT_IMP(a_alloc_sets_clear_bit, (state_q == pba_pkg::ST_ACHK) && ram_we,
                  ram_wdata != ram_rdata, "alloc hit a used page")
  `PBA_ASSERT(a_alloc_counts_up,
              (state_q == pba_pkg::ST_ACHK) && ram_we |=> used_q == $past(used_q) + 1'b1,
              "alloc did not count the page")
  `PBA_ASSERT(a_rsp_from_fin, $rose(ov_q) |-> $past(state_q == pba_pkg::ST_FIN),
              "result shown outside finish")

endmodule

`default_nettype wire
